// ===== rtl/core/quaternion_alu_assert.svh =====
// Assertion macros for the quaternion ALU
`ifndef QUATERNION_ALU_ASSERT_SVH
`define QUATERNION_ALU_ASSERT_SVH
`ifndef SYNTHESIS
`define QA_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define QA_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define QA_ASSERT_IMP(label, clk, rst, a, c, msg)
`define QA_ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

// ===== rtl/core/qalu_pkg.sv =====
// Shared types and constants for the quaternion ALU
package qalu_pkg;
  localparam int FracBitsDefault = 16;
  localparam int LimitDefault    = 7;

  typedef enum logic [3:0] {
    OP_LOAD = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3,
    OP_CONJ = 4'd4, OP_INV = 4'd5, OP_CROSS = 4'd6, OP_DOT = 4'd7,
    OP_NORM = 4'd8, OP_MAG = 4'd9, OP_MAGSQ = 4'd10, OP_UNIT = 4'd11,
    OP_IDENT = 4'd12, OP_NOP13 = 4'd13, OP_NOP14 = 4'd14, OP_NOP15 = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MULT, ST_SUM, ST_SQRT, ST_DIV, ST_DONE
  } state_t;

  // lane control from the sequencer
  typedef struct packed {
    logic start;
    logic use_div;
  } lane_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

// ===== rtl/core/qalu_lane.sv =====
// One lane: multiply-accumulate of four products and a serial divider
module qalu_lane import qalu_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lane_ctl_t             ctl,
  input  logic signed [31:0]    a0, b0, a1, b1, a2, b2, a3, b3,
  input  logic [3:0]            neg,
  input  logic signed [32:0]    numer,
  input  logic [64-FRAC_BITS:0] denom,
  output logic signed [31:0]    rsum,
  output logic [65:0]           sumsq,
  output logic signed [31:0]    quot,
  output logic                  busy
);
  // denominator width and divider length; the divider must hold the scaled
  // numerator and stay wider than the largest denominator
  localparam int DW = 65 - FRAC_BITS;
  localparam int QW = (41 + FRAC_BITS > DW) ? 41 + FRAC_BITS : DW + 1;
  logic signed [63:0] p0, p1, p2, p3;
  logic signed [66:0] tot;
  logic signed [66:0] rnd;
  logic [QW-1:0] rem, qacc;
  logic [6:0] cnt;
  logic neg_q;
  logic [32:0] nmag;
  logic [QW:0] trial;
  logic [QW-1:0] q_round;
  logic [QW-1:0] q_cap;

  // product registers, one multiplier per product
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      p0 <= neg[0] ? -(a0 * b0) : a0 * b0;
      p1 <= neg[1] ? -(a1 * b1) : a1 * b1;
      p2 <= neg[2] ? -(a2 * b2) : a2 * b2;
      p3 <= neg[3] ? -(a3 * b3) : a3 * b3;
    end
  end

  assign tot  = 67'(p0) + 67'(p1) + 67'(p2) + 67'(p3);
  assign rnd  = (tot + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign rsum = sat32(72'(rnd));
  assign sumsq = tot[65:0];

  // numerator magnitude, up to 2^31
  assign nmag = numer[32] ? 33'(-numer) : 33'(numer);

  // restoring divider: dividend bits leave qacc from the top, quotient bits enter below
  assign trial = {rem, qacc[QW-1]} - (QW+1)'(denom);
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start && ctl.use_div) begin
      busy  <= 1'b1;
      cnt   <= 7'(QW);
      neg_q <= numer[32];
      rem   <= '0;
      qacc  <= (QW'(nmag) << FRAC_BITS) + QW'(denom >> 1);
    end else if (busy) begin
      if (!trial[QW]) begin
        rem  <= trial[QW-1:0];
        qacc <= {qacc[QW-2:0], 1'b1};
      end else begin
        rem  <= {rem[QW-2:0], qacc[QW-1]};
        qacc <= {qacc[QW-2:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

  assign q_round = qacc;
  assign q_cap = (q_round > (QW'(1) << 40)) ? (QW'(1) << 40) : q_round;
  assign quot = sat32(neg_q ? -72'(q_cap) : 72'(q_cap));
endmodule

// ===== rtl/core/qalu_sqrt.sv =====
// Serial square root, two radicand bits per cycle, rounded to nearest
module qalu_sqrt import qalu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic [32:0] root,
  output logic        busy
);
  logic [63:0] v, r, bitm;
  logic [5:0]  cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      v    <= rad;
      r    <= '0;
      bitm <= 64'h4000000000000000;
      cnt  <= 6'd32;
    end else if (busy) begin
      if (v >= r + bitm) begin
        v <= v - (r + bitm);
        r <= (r >> 1) + bitm;
      end else begin
        r <= r >> 1;
      end
      bitm <= bitm >> 2;
      cnt  <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  // v now holds s - r*r
  assign root = (v > r) ? 33'(r) + 33'd1 : 33'(r);
endmodule

// ===== rtl/core/quaternion_alu.sv =====
// Quaternion ALU: mode decode, four lanes, square root, result merge
// Throughput: one item at a time; a new item is taken only in the idle state with no
//   result beat waiting. The serial divider in each lane and the two-bit-per-cycle
//   square root make mag, inverse and normalize the slow modes.
// Reset: accumulator to identity, limit to 7, output beat empty.
`include "quaternion_alu_assert.svh"
module quaternion_alu import qalu_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // mode, in_x, in_y, in_z, in_w, pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,   // out_x..out_w, scalar_result, is_unit, pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data        // small_magnitude_limit
);
  // rounded magnitude squared reaches 2^(64-FRAC_BITS)
  localparam int DW = 65 - FRAC_BITS;
  state_t st, st_next;
  logic [15:0] limit;
  logic signed [31:0] ax, ay, az, aw, bx, by, bz, bw, scal;
  logic unit;
  op_t op;
  logic in_acc;
  lane_ctl_t ctl;
  logic signed [31:0] la0[4], lb0[4], la1[4], lb1[4], la2[4], lb2[4], la3[4], lb3[4];
  logic [3:0] lneg[4];
  logic signed [32:0] lnum[4];
  logic signed [31:0] lrs[4], lq[4];
  logic [65:0] lss[4];
  logic [3:0] lbusy;
  logic [DW-1:0] denom;
  logic sq_start, sq_busy;
  logic [32:0] root;
  logic [63:0] ssq;
  logic [DW-1:0] dsq;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign s_axis_tready = (st == ST_IDLE) && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) limit <= 16'(LimitDefault);
    else if (cfg_valid) limit <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op <= op_t'(s_axis_tdata[3:0]);
      bx <= s_axis_tdata[35:4];
      by <= s_axis_tdata[67:36];
      bz <= s_axis_tdata[99:68];
      bw <= s_axis_tdata[131:100];
    end
  end

  // lane 0 is x, 1 y, 2 z, 3 w; operands chosen by opcode
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      la0[i] = ax; lb0[i] = ax; la1[i] = ay; lb1[i] = ay;
      la2[i] = az; lb2[i] = az; la3[i] = aw; lb3[i] = aw; lneg[i] = 4'b0;
    end
    unique case (op)
      OP_MUL: begin
        la0[0]=aw; lb0[0]=bx; la1[0]=ax; lb1[0]=bw; la2[0]=ay; lb2[0]=bz; la3[0]=az; lb3[0]=by;
        lneg[0]=4'b0100;
        la0[1]=aw; lb0[1]=by; la1[1]=ay; lb1[1]=bw; la2[1]=ax; lb2[1]=bz; la3[1]=az; lb3[1]=bx;
        lneg[1]=4'b1000;
        la0[2]=aw; lb0[2]=bz; la1[2]=az; lb1[2]=bw; la2[2]=ax; lb2[2]=by; la3[2]=ay; lb3[2]=bx;
        lneg[2]=4'b0100;
        la0[3]=aw; lb0[3]=bw; la1[3]=ax; lb1[3]=bx; la2[3]=ay; lb2[3]=by; la3[3]=az; lb3[3]=bz;
        lneg[3]=4'b1110;
      end
      OP_CROSS: begin
        for (int i = 0; i < 4; i++) begin
          lb2[i] = '0; lb3[i] = '0;
        end
        la0[0]=ay; lb0[0]=bz; la1[0]=az; lb1[0]=by; lneg[0]=4'b0010;
        la0[1]=az; lb0[1]=bx; la1[1]=ax; lb1[1]=bz; lneg[1]=4'b0010;
        la0[2]=ax; lb0[2]=by; la1[2]=ay; lb1[2]=bx; lneg[2]=4'b0010;
      end
      OP_DOT: begin
        lb0[0]=bx; lb1[0]=by; lb2[0]=bz; lb3[0]=bw;
      end
      default: ;
    endcase
  end

  // saturated sum of squares: only all -2^31 overflows 64 bits
  assign ssq = lss[0][65:64] != 2'b00 ? 64'hffffffffffffffff : lss[0][63:0];
  assign dsq = DW'((ssq >> FRAC_BITS) + 64'(ssq[FRAC_BITS-1]));
  assign denom = (op == OP_INV) ? dsq : DW'(root);
  // numerators are 33 bits so that negating -2^31 stays exact
  assign lnum[0] = (op == OP_INV) ? -33'(ax) : 33'(ax);
  assign lnum[1] = (op == OP_INV) ? -33'(ay) : 33'(ay);
  assign lnum[2] = (op == OP_INV) ? -33'(az) : 33'(az);
  assign lnum[3] = 33'(aw);

  for (genvar g = 0; g < 4; g++) begin : g_lane
    qalu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk, .rst, .ctl,
      .a0(la0[g]), .b0(lb0[g]), .a1(la1[g]), .b1(lb1[g]),
      .a2(la2[g]), .b2(lb2[g]), .a3(la3[g]), .b3(lb3[g]),
      .neg(lneg[g]), .numer(lnum[g]), .denom,
      .rsum(lrs[g]), .sumsq(lss[g]), .quot(lq[g]), .busy(lbusy[g])
    );
  end

  qalu_sqrt u_sqrt (.clk, .rst, .start(sq_start), .rad(ssq), .root, .busy(sq_busy));

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: if (in_acc) st_next = ST_MULT;
      ST_MULT: st_next = ST_SUM;
      ST_SUM: begin
        if (op == OP_NORM || op == OP_MAG) st_next = ST_SQRT;
        else if (op == OP_INV && dsq > DW'(limit)) st_next = ST_DIV;
        else st_next = ST_DONE;
      end
      ST_SQRT: if (!sq_busy && !sq_start) begin
        if (op == OP_NORM && root > 33'(limit)) st_next = ST_DIV;
        else st_next = ST_DONE;
      end
      ST_DIV: if (lbusy == 4'b0 && !ctl.start) st_next = ST_DONE;
      ST_DONE: st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctl.start = 1'b0;
    ctl.use_div = 1'b0;
    sq_start = 1'b0;
    unique case (st)
      ST_MULT: ctl.start = 1'b1;
      ST_SUM: begin
        sq_start = (op == OP_NORM || op == OP_MAG);
        ctl.start = (op == OP_INV && dsq > DW'(limit));
        ctl.use_div = ctl.start;
      end
      ST_SQRT: begin
        ctl.start = !sq_busy && !sq_start && op == OP_NORM && root > 33'(limit);
        ctl.use_div = ctl.start;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= ST_IDLE;
    else st <= st_next;
  end

  // merge: accumulator update and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= '0; ay <= '0; az <= '0; aw <= 32'(1) << FRAC_BITS;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (st == ST_DONE) begin
        m_axis_tvalid <= 1'b1;
        scal <= '0;
        unit <= 1'b0;
        case (op) inside
          OP_LOAD: begin ax <= bx; ay <= by; az <= bz; aw <= bw; end
          OP_ADD: begin
            ax <= sat32(72'(ax) + 72'(bx)); ay <= sat32(72'(ay) + 72'(by));
            az <= sat32(72'(az) + 72'(bz)); aw <= sat32(72'(aw) + 72'(bw));
          end
          OP_SUB: begin
            ax <= sat32(72'(ax) - 72'(bx)); ay <= sat32(72'(ay) - 72'(by));
            az <= sat32(72'(az) - 72'(bz)); aw <= sat32(72'(aw) - 72'(bw));
          end
          OP_MUL: begin ax <= lrs[0]; ay <= lrs[1]; az <= lrs[2]; aw <= lrs[3]; end
          OP_CROSS: begin ax <= lrs[0]; ay <= lrs[1]; az <= lrs[2]; aw <= '0; end
          OP_CONJ: begin
            ax <= sat32(-72'(ax)); ay <= sat32(-72'(ay)); az <= sat32(-72'(az));
          end
          OP_INV, OP_NORM: begin
            if ((op == OP_INV && dsq > DW'(limit)) || (op == OP_NORM && root > 33'(limit))) begin
              ax <= lq[0]; ay <= lq[1]; az <= lq[2]; aw <= lq[3];
            end else begin
              ax <= '0; ay <= '0; az <= '0; aw <= 32'(1) << FRAC_BITS;
            end
          end
          OP_DOT: scal <= lrs[0];
          OP_MAG: scal <= (root > 33'h7fffffff) ? 32'sh7fffffff : root[31:0];
          OP_MAGSQ: scal <= (dsq > DW'(32'h7fffffff)) ? 32'sh7fffffff : dsq[31:0];
          OP_UNIT: unit <= (ssq == (64'd1 << (2 * FRAC_BITS)));
          OP_IDENT: begin ax <= '0; ay <= '0; az <= '0; aw <= 32'(1) << FRAC_BITS; end
          default: ;
        endcase
      end
    end
  end

  assign m_axis_tdata = {7'd0, unit, scal, aw, az, ay, ax};

  `QA_ASSERT_IMP(a_no_accept_busy, clk, rst, st != ST_IDLE, !s_axis_tready, "accepted while busy")
  `QA_ASSERT_NEXT(a_done_valid, clk, rst, st == ST_DONE, m_axis_tvalid, "result not shown")
  `QA_ASSERT_IMP(a_div_idle, clk, rst, st == ST_IDLE, lbusy == 4'b0, "divider running when idle")
endmodule

// ===== sim/quaternion_alu_checker.sv =====
// Checker for the quaternion ALU: watches all channels, predicts each result and compares
`timescale 1ns / 1ps
module quaternion_alu_checker import qalu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // mode, in_x, in_y, in_z, in_w, pad
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [167:0] m_axis_tdata,   // out_x..out_w, scalar_result, is_unit, pad
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [15:0]  cfg_data,       // small_magnitude_limit
  output int           fail_count,
  output int           pending
);
  localparam int FB = FracBitsDefault;

  typedef struct {
    logic signed [31:0] x, y, z, w, scalar;
    logic               unit;
  } quat_result_t;

  quat_result_t       result_q[$];
  logic signed [31:0] qx, qy, qz, qw;
  logic [15:0]        mag_limit;

  function automatic logic signed [31:0] clamp32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] prod(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] ea, eb;
    ea = a;
    eb = b;
    return ea * eb;
  endfunction

  // exact sum, round half up, saturate
  function automatic logic signed [31:0] rnd4(input logic signed [63:0] p0, p1, p2, p3);
    logic signed [71:0] s, e0, e1, e2, e3;
    e0 = p0; e1 = p1; e2 = p2; e3 = p3;
    s = e0 + e1 + e2 + e3 + 72'sd32768;
    return clamp32(s >>> FB);
  endfunction

  function automatic logic [63:0] sumsq(input logic signed [31:0] a, b, c, d);
    logic [65:0] s;
    s = 66'(prod(a, a)) + 66'(prod(b, b)) + 66'(prod(c, c)) + 66'(prod(d, d));
    if (s > 66'h0ffffffffffffffff) return 64'hffffffffffffffff;
    return s[63:0];
  endfunction

  // integer root rounded to nearest
  function automatic logic [63:0] root_rnd(input logic [63:0] s);
    logic [63:0] v, r, b;
    v = s;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  // c * 2^FB / d, halves away from zero, saturated
  function automatic logic signed [31:0] qdiv(input logic signed [63:0] c,
                                              input logic [63:0] d);
    logic signed [63:0] n, sq;
    logic [63:0]        m, q;
    n = c * 64'sd65536;
    m = (n < 0) ? 64'(-n) : 64'(n);
    q = (m + d / 2) / d;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    sq = q;
    return clamp32(72'(n < 0 ? -sq : sq));
  endfunction

  task automatic set_identity();
    qx = 0; qy = 0; qz = 0; qw = 32'sd65536;
  endtask

  // advance the accumulator by one item and return what the block should emit
  task automatic predict_step(input logic [135:0] td, output quat_result_t r);
    op_t                op;
    logic signed [31:0] bx, by, bz, bw, x, y, z, w;
    logic signed [71:0] t;
    logic [63:0]        s, d;
    op = op_t'(td[3:0]);
    bx = td[35:4]; by = td[67:36]; bz = td[99:68]; bw = td[131:100];
    x = qx; y = qy; z = qz; w = qw;
    r.scalar = 0;
    r.unit = 0;
    case (op)
      OP_LOAD: begin
        qx = bx; qy = by; qz = bz; qw = bw;
      end
      OP_ADD: begin
        qx = clamp32(72'(x) + 72'(bx)); qy = clamp32(72'(y) + 72'(by));
        qz = clamp32(72'(z) + 72'(bz)); qw = clamp32(72'(w) + 72'(bw));
      end
      OP_SUB: begin
        qx = clamp32(72'(x) - 72'(bx)); qy = clamp32(72'(y) - 72'(by));
        qz = clamp32(72'(z) - 72'(bz)); qw = clamp32(72'(w) - 72'(bw));
      end
      OP_MUL: begin
        qx = rnd4(prod(w, bx), prod(x, bw), -prod(y, bz), prod(z, by));
        qy = rnd4(prod(w, by), prod(y, bw), prod(x, bz), -prod(z, bx));
        qz = rnd4(prod(w, bz), prod(z, bw), -prod(x, by), prod(y, bx));
        qw = rnd4(prod(w, bw), -prod(x, bx), -prod(y, by), -prod(z, bz));
      end
      OP_CONJ: begin
        qx = clamp32(-72'(x)); qy = clamp32(-72'(y)); qz = clamp32(-72'(z));
      end
      OP_INV: begin
        s = sumsq(x, y, z, w);
        d = (s >> FB) + ((s >> (FB - 1)) & 64'd1);
        if (d > 64'(mag_limit)) begin
          qx = qdiv(-64'(x), d); qy = qdiv(-64'(y), d);
          qz = qdiv(-64'(z), d); qw = qdiv(64'(w), d);
        end else begin
          set_identity();
        end
      end
      OP_CROSS: begin
        qx = rnd4(prod(y, bz), -prod(z, by), 0, 0);
        qy = rnd4(prod(z, bx), -prod(x, bz), 0, 0);
        qz = rnd4(prod(x, by), -prod(y, bx), 0, 0);
        qw = 0;
      end
      OP_DOT: r.scalar = rnd4(prod(x, bx), prod(y, by), prod(z, bz), prod(w, bw));
      OP_NORM: begin
        d = root_rnd(sumsq(x, y, z, w));
        if (d > 64'(mag_limit)) begin
          qx = qdiv(64'(x), d); qy = qdiv(64'(y), d);
          qz = qdiv(64'(z), d); qw = qdiv(64'(w), d);
        end else begin
          set_identity();
        end
      end
      OP_MAG: begin
        d = root_rnd(sumsq(x, y, z, w));
        r.scalar = (d > 64'h7fffffff) ? 32'sh7fffffff : d[31:0];
      end
      OP_MAGSQ: begin
        s = sumsq(x, y, z, w);
        d = (s >> FB) + ((s >> (FB - 1)) & 64'd1);
        r.scalar = (d > 64'h7fffffff) ? 32'sh7fffffff : d[31:0];
      end
      OP_UNIT: r.unit = (sumsq(x, y, z, w) == (64'd1 << (2 * FB)));
      OP_IDENT: set_identity();
      default: ;
    endcase
    r.x = qx; r.y = qy; r.z = qz; r.w = qw;
  endtask

  assign pending = result_q.size();

  always @(posedge clk) begin
    quat_result_t exp_r, got;
    if (rst) begin
      set_identity();
      mag_limit <= 16'd7;
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) mag_limit <= cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_step(s_axis_tdata, exp_r);
        result_q.push_back(exp_r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[31:0];    got.y = m_axis_tdata[63:32];
        got.z = m_axis_tdata[95:64];   got.w = m_axis_tdata[127:96];
        got.scalar = m_axis_tdata[159:128];
        got.unit = m_axis_tdata[160];
        if (result_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat: %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (got.x !== exp_r.x || got.y !== exp_r.y || got.z !== exp_r.z ||
              got.w !== exp_r.w || got.scalar !== exp_r.scalar ||
              got.unit !== exp_r.unit) begin
            if (fail_count < 10)
              $display("mismatch: exp x=%h y=%h z=%h w=%h s=%h u=%b  got x=%h y=%h z=%h w=%h s=%h u=%b",
                       exp_r.x, exp_r.y, exp_r.z, exp_r.w, exp_r.scalar, exp_r.unit,
                       got.x, got.y, got.z, got.w, got.scalar, got.unit);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/tb_quaternion_alu.sv =====
// Testbench top for the quaternion ALU: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module tb_quaternion_alu;
  import qalu_pkg::*;

  localparam int IdleLimit = 20000;
  localparam logic [31:0] QMin = 32'h80000000, QMax = 32'h7fffffff, QOne = 32'h00010000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;   // mode, in_x, in_y, in_z, in_w, pad
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [167:0] m_axis_tdata;        // out_x..out_w, scalar_result, is_unit, pad
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;       // small_magnitude_limit
  int           fail_count, pending;
  int           tx_pct = 0, rx_pct = 0;
  bit           hold_req = 0;
  int           idle_cycles = 0;

  quaternion_alu dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  quaternion_alu_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 0;
        repeat (600) @(posedge clk);
        hold_req = 0;
      end else begin
        m_axis_tready <= !rst && ($urandom_range(99) >= rx_pct);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_q(input op_t op, input logic [31:0] x, y, z, w);
    while ($urandom_range(99) < tx_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tdata  <= {4'b0, w, z, y, x, op};
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // wait for the block to drain, then write the limit
  task automatic set_limit(input logic [15:0] v);
    s_axis_tvalid <= 0;
    // let the checker record a beat taken at this same edge
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(262143)) - 131072);
      2: case ($urandom_range(5))
           0: return QMin;
           1: return QMax;
           2: return 0;
           3: return QOne;
           4: return -QOne;
           default: return 1;
         endcase
      3: return 32'($signed($urandom_range(16)) - 8);
      default: return 32'($signed($urandom_range(2097151)) - 1048576);
    endcase
  endfunction

  task automatic rand_items(input int n);
    op_t op;
    for (int i = 0; i < n; i++) begin
      // mostly real operations, loads fairly often to refresh the accumulator
      if ($urandom_range(9) < 3) op = OP_LOAD;
      else if ($urandom_range(19) == 0) op = op_t'($urandom_range(13, 15));
      else op = op_t'($urandom_range(0, 12));
      send_q(op, rand_part(), rand_part(), rand_part(), rand_part());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    set_limit(16'd7);

    // directed corners
    send_q(OP_UNIT, 0, 0, 0, 0);
    send_q(OP_LOAD, QMin, QMin, QMin, QMin);
    send_q(OP_MAG, 0, 0, 0, 0);
    send_q(OP_MAGSQ, 0, 0, 0, 0);
    send_q(OP_DOT, QMin, QMin, QMin, QMin);
    send_q(OP_CONJ, 0, 0, 0, 0);
    send_q(OP_ADD, QMax, QMax, QMax, QMax);
    send_q(OP_SUB, QMin, QMin, QMin, QMin);
    send_q(OP_MUL, QMax, QMin, QMax, QMin);
    send_q(OP_CROSS, QMin, QMax, 3, -5);
    send_q(OP_LOAD, 1, -2, 1, 0);
    send_q(OP_INV, 0, 0, 0, 0);
    send_q(OP_LOAD, 3, 0, -2, 1);
    send_q(OP_NORM, 0, 0, 0, 0);
    send_q(OP_LOAD, 32'h30000, 32'h40000, 0, 0);
    send_q(OP_NORM, 0, 0, 0, 0);
    send_q(OP_UNIT, 0, 0, 0, 0);
    send_q(OP_LOAD, QMax, QMax, QMax, QMax);
    send_q(OP_INV, 0, 0, 0, 0);
    send_q(OP_NORM, 0, 0, 0, 0);
    send_q(OP_NOP13, QMax, 0, 0, 0);
    send_q(OP_NOP14, 0, 0, 0, 0);
    send_q(OP_NOP15, QMin, QMin, QMin, QMin);
    send_q(OP_IDENT, 0, 0, 0, 0);
    send_q(OP_UNIT, 0, 0, 0, 0);

    // random phases over limits and idling patterns
    rand_items(300);
    tx_pct = 48;
    set_limit(16'd0);
    rand_items(300);
    tx_pct = 0;
    rx_pct = 48;
    set_limit(16'hffff);
    rand_items(300);
    hold_req = 1;
    rand_items(40);
    tx_pct = 35;
    rx_pct = 35;
    set_limit(16'($urandom));
    rand_items(260);
    tx_pct = 0;
    rx_pct = 0;
    set_limit(16'd7);
    rand_items(250);

    // drain
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/qalu_pkg.sv
rtl/core/qalu_lane.sv
rtl/core/qalu_sqrt.sv
rtl/core/quaternion_alu.sv
sim/quaternion_alu_checker.sv
sim/tb_quaternion_alu.sv
